// ----- sv/assert_macros.svh -----
// Assertion macros used by sum_checked_frame_parser, the top of the frame parser.
// No dependencies; ASSERT_OFF removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");

// cond at an edge implies expr at that edge
`define ASSERT_IMPLIES(lbl, clk, rstn, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLIES(lbl, clk, rstn, cond, expr)

`endif

`endif

// ----- sv/scfp_pkg.sv -----
// Shared types and constants of the sum checked frame parser.
// No dependencies.
`default_nettype none

package scfp_pkg;

    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int REPORT_WIDTH      = 32;

    localparam logic [1:0] STAT_NONE     = 2'd0;
    localparam logic [1:0] STAT_GOOD     = 2'd1;
    localparam logic [1:0] STAT_BAD_TAIL = 2'd2;
    localparam logic [1:0] STAT_BAD_SUM  = 2'd3;

    localparam logic REG_HEAD = 1'b0;
    localparam logic REG_TAIL = 1'b1;

    localparam logic [2:0] POS_IDLE     = 3'd0;
    localparam logic [2:0] POS_FIRST    = 3'd1;
    localparam logic [2:0] POS_CHECKSUM = 3'd6;
    localparam logic [2:0] POS_TAIL     = 3'd7;

    localparam int NUM_DATA = 6;
    localparam logic [2:0] IDX_SEQ   = 3'd0;
    localparam logic [2:0] IDX_FLAGS = 3'd1;
    localparam logic [2:0] IDX_ERR   = 3'd2;
    localparam logic [2:0] IDX_AREA  = 3'd3;
    localparam logic [2:0] IDX_CONF  = 3'd4;
    localparam logic [2:0] IDX_CHK   = 3'd5;

    localparam logic signed [7:0] ERR_MAX  = 8'sd100;
    localparam logic signed [7:0] ERR_MIN  = -8'sd100;
    localparam logic [7:0]        CONF_MAX = 8'd100;

    typedef struct packed {
        logic byte_in;
        logic good;
        logic bad_tail;
        logic bad_sum;
    } frame_evt_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        seq;
        logic [7:0]        flags;
        logic signed [7:0] err;
        logic [7:0]        area;
        logic [6:0]        conf;
    } frame_res_t;

    typedef struct packed {
        logic [REPORT_WIDTH-1:0] bytes;
        logic [REPORT_WIDTH-1:0] good;
        logic [REPORT_WIDTH-1:0] bad_tail;
        logic [REPORT_WIDTH-1:0] bad_sum;
    } cnt_rpt_t;

endpackage

`default_nettype wire

// ----- sv/sum_checked_frame_parser.sv -----
// The input byte is registered in the input register, then the result in the
// result register. Throughput: one byte per cycle, set by the single
// compare-and-add pass between the two registers; stalls only on out_ready.
// Reset: asynchronous, active low; clears position, counters, head and tail
// registers and the valid flags. Depends on scfp_pkg, scfp_frame, scfp_counters.
`default_nettype none

`include "assert_macros.svh"

module sum_checked_frame_parser #(
    parameter int COUNTER_WIDTH = scfp_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       frame_status,
    output logic [7:0]       sequence_number,
    output logic [7:0]       flag_bits,
    output logic signed [7:0] aim_error,
    output logic [7:0]       target_area,
    output logic [6:0]       confidence_level,
    output logic [31:0]      bytes_seen,
    output logic [31:0]      good_frames,
    output logic [31:0]      bad_tail_frames,
    output logic [31:0]      bad_sum_frames
);

    logic [7:0]           head_reg;
    logic [7:0]           tail_reg;
    logic                 s1_vld_reg;
    logic [7:0]           s1_byte_reg;
    logic                 out_vld_reg;
    logic                 advance;
    logic                 res_good;
    logic                 res_zero;
    logic                 res_in_range;
    scfp_pkg::frame_res_t res;
    scfp_pkg::frame_evt_t evt;
    scfp_pkg::cnt_rpt_t   rpt;
    scfp_pkg::frame_res_t res_reg;
    scfp_pkg::cnt_rpt_t   rpt_reg;

    assign cfg_ready = 1'b1;
    assign advance   = s1_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !s1_vld_reg || advance;
    assign out_valid = out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 8'd0;
            tail_reg <= 8'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                scfp_pkg::REG_HEAD: head_reg <= cfg_data;
                scfp_pkg::REG_TAIL: tail_reg <= cfg_data;
                default:            tail_reg <= tail_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (advance)
        begin
            res_reg <= res;
            rpt_reg <= rpt;
        end
    end

    scfp_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (s1_byte_reg),
        .head_byte (head_reg),
        .tail_byte (tail_reg),
        .res       (res),
        .evt       (evt)
    );

    scfp_counters #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_counters (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .rpt   (rpt)
    );

    assign frame_status     = res_reg.status;
    assign sequence_number  = res_reg.seq;
    assign flag_bits        = res_reg.flags;
    assign aim_error        = res_reg.err;
    assign target_area      = res_reg.area;
    assign confidence_level = res_reg.conf;
    assign bytes_seen       = rpt_reg.bytes;
    assign good_frames      = rpt_reg.good;
    assign bad_tail_frames  = rpt_reg.bad_tail;
    assign bad_sum_frames   = rpt_reg.bad_sum;

    assign res_good     = (res_reg.status == scfp_pkg::STAT_GOOD);
    assign res_zero     = (res_reg.seq == 8'd0) && (res_reg.flags == 8'd0)
                          && (res_reg.err == 8'sd0) && (res_reg.area == 8'd0)
                          && (res_reg.conf == 7'd0);
    assign res_in_range = (res_reg.err <= scfp_pkg::ERR_MAX)
                          && (res_reg.err >= scfp_pkg::ERR_MIN)
                          && (res_reg.conf <= scfp_pkg::CONF_MAX[6:0]);

    `ASSERT_ALWAYS(a_ready_when_empty, clk, rst_n, s1_vld_reg || in_ready)
    `ASSERT_IMPLIES(a_idle_accepts, clk, rst_n, !out_vld_reg, in_ready)
    `ASSERT_IMPLIES(a_reject_zero, clk, rst_n, out_vld_reg && !res_good, res_zero)
    `ASSERT_IMPLIES(a_good_clamped, clk, rst_n, out_vld_reg && res_good, res_in_range)
    `ASSERT_IMPLIES(a_one_outcome, clk, rst_n, advance, $countones({evt.good, evt.bad_tail, evt.bad_sum}) <= 1)

endmodule

`default_nettype wire

// ----- sv/scfp_frame.sv -----
// Frame assembly: byte position, stored frame bytes, running checksum and
// the checks on the tail byte. Depends on scfp_pkg.
`default_nettype none

module scfp_frame (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [7:0]         rx_byte,
    input  wire logic [7:0]         head_byte,
    input  wire logic [7:0]         tail_byte,
    output scfp_pkg::frame_res_t    res,
    output scfp_pkg::frame_evt_t    evt
);

    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] frame_bytes_reg [scfp_pkg::NUM_DATA];
    logic       wr_en;
    logic [2:0] wr_idx;
    logic signed [7:0] err_raw;
    logic [7:0] conf_raw;

    assign wr_idx   = pos_reg - 3'd1;
    assign err_raw  = frame_bytes_reg[scfp_pkg::IDX_ERR];
    assign conf_raw = frame_bytes_reg[scfp_pkg::IDX_CONF];

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        wr_en    = 1'b0;
        res      = '0;
        if (pos_reg == scfp_pkg::POS_IDLE)
        begin
            if (rx_byte == head_byte)
            begin
                pos_next = scfp_pkg::POS_FIRST;
            end
        end
        else if (pos_reg != scfp_pkg::POS_TAIL)
        begin
            wr_en    = 1'b1;
            pos_next = pos_reg + 3'd1;
            if (pos_reg == scfp_pkg::POS_FIRST)
            begin
                sum_next = rx_byte;
            end
            else if (pos_reg != scfp_pkg::POS_CHECKSUM)
            begin
                sum_next = sum_reg + rx_byte;
            end
        end
        else
        begin
            pos_next = scfp_pkg::POS_IDLE;
            if (rx_byte != tail_byte)
            begin
                res.status = scfp_pkg::STAT_BAD_TAIL;
            end
            else if (sum_reg != frame_bytes_reg[scfp_pkg::IDX_CHK])
            begin
                res.status = scfp_pkg::STAT_BAD_SUM;
            end
            else
            begin
                res.status = scfp_pkg::STAT_GOOD;
                res.seq    = frame_bytes_reg[scfp_pkg::IDX_SEQ];
                res.flags  = frame_bytes_reg[scfp_pkg::IDX_FLAGS];
                res.area   = frame_bytes_reg[scfp_pkg::IDX_AREA];
                if (err_raw > scfp_pkg::ERR_MAX)
                begin
                    res.err = scfp_pkg::ERR_MAX;
                end
                else if (err_raw < scfp_pkg::ERR_MIN)
                begin
                    res.err = scfp_pkg::ERR_MIN;
                end
                else
                begin
                    res.err = err_raw;
                end
                if (conf_raw > scfp_pkg::CONF_MAX)
                begin
                    res.conf = scfp_pkg::CONF_MAX[6:0];
                end
                else
                begin
                    res.conf = conf_raw[6:0];
                end
            end
        end
    end

    assign evt.byte_in  = step;
    assign evt.good     = step && (res.status == scfp_pkg::STAT_GOOD);
    assign evt.bad_tail = step && (res.status == scfp_pkg::STAT_BAD_TAIL);
    assign evt.bad_sum  = step && (res.status == scfp_pkg::STAT_BAD_SUM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= scfp_pkg::POS_IDLE;
        end
        else if (step)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            sum_reg <= sum_next;
            if (wr_en)
            begin
                frame_bytes_reg[wr_idx] <= rx_byte;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/scfp_counters.sv -----
// Wrapping byte and frame outcome counters, reported in 32-bit fields.
// Depends on scfp_pkg.
`default_nettype none

module scfp_counters #(
    parameter int COUNTER_WIDTH = scfp_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  scfp_pkg::frame_evt_t evt,
    output scfp_pkg::cnt_rpt_t   rpt
);

    localparam int EXT_W = COUNTER_WIDTH + scfp_pkg::REPORT_WIDTH;

    logic [COUNTER_WIDTH-1:0] byte_cnt_reg;
    logic [COUNTER_WIDTH-1:0] good_cnt_reg;
    logic [COUNTER_WIDTH-1:0] tail_cnt_reg;
    logic [COUNTER_WIDTH-1:0] sum_cnt_reg;
    logic [COUNTER_WIDTH-1:0] byte_cnt_next;
    logic [COUNTER_WIDTH-1:0] good_cnt_next;
    logic [COUNTER_WIDTH-1:0] tail_cnt_next;
    logic [COUNTER_WIDTH-1:0] sum_cnt_next;
    logic [EXT_W-1:0]         byte_ext;
    logic [EXT_W-1:0]         good_ext;
    logic [EXT_W-1:0]         tail_ext;
    logic [EXT_W-1:0]         sum_ext;

    assign byte_cnt_next = evt.byte_in  ? byte_cnt_reg + 1'b1 : byte_cnt_reg;
    assign good_cnt_next = evt.good     ? good_cnt_reg + 1'b1 : good_cnt_reg;
    assign tail_cnt_next = evt.bad_tail ? tail_cnt_reg + 1'b1 : tail_cnt_reg;
    assign sum_cnt_next  = evt.bad_sum  ? sum_cnt_reg + 1'b1  : sum_cnt_reg;

    // counts including the current byte, zero-extended then cut to 32 bits
    assign byte_ext = {{scfp_pkg::REPORT_WIDTH{1'b0}}, byte_cnt_next};
    assign good_ext = {{scfp_pkg::REPORT_WIDTH{1'b0}}, good_cnt_next};
    assign tail_ext = {{scfp_pkg::REPORT_WIDTH{1'b0}}, tail_cnt_next};
    assign sum_ext  = {{scfp_pkg::REPORT_WIDTH{1'b0}}, sum_cnt_next};

    assign rpt.bytes    = byte_ext[scfp_pkg::REPORT_WIDTH-1:0];
    assign rpt.good     = good_ext[scfp_pkg::REPORT_WIDTH-1:0];
    assign rpt.bad_tail = tail_ext[scfp_pkg::REPORT_WIDTH-1:0];
    assign rpt.bad_sum  = sum_ext[scfp_pkg::REPORT_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= '0;
            good_cnt_reg <= '0;
            tail_cnt_reg <= '0;
            sum_cnt_reg  <= '0;
        end
        else
        begin
            byte_cnt_reg <= byte_cnt_next;
            good_cnt_reg <= good_cnt_next;
            tail_cnt_reg <= tail_cnt_next;
            sum_cnt_reg  <= sum_cnt_next;
        end
    end

endmodule

`default_nettype wire
